[hdl/pkdc_pkg.sv]
package pkdc_pkg;

    localparam int COORD_BITS = 8;
    localparam int KEY_BITS   = 8;
    localparam int DIFF_W     = COORD_BITS + 1;
    localparam int HELD_W     = (DIFF_W > 8) ? DIFF_W : 8;
    localparam int CMP_W      = (DIFF_W + 1 > 10) ? DIFF_W + 1 : 10;
    localparam int LIMIT_W    = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    // tangents in Q24
    localparam int TAN_W = 26;
    localparam int FRAC_BITS = 24;
    localparam logic [TAN_W-1:0] TAN225_Q24 = TAN_W'(6949350);
    localparam logic [TAN_W-1:0] TAN45_Q24  = TAN_W'(16777216);
    localparam logic [TAN_W-1:0] TAN675_Q24 = TAN_W'(40503782);

    localparam logic signed [HELD_W-1:0] HELD_RESET = HELD_W'(99);
    localparam logic [LIMIT_W-1:0] NEAR_RESET = LIMIT_W'(5);

    localparam logic [CFG_IDX_W-1:0] CFG_SIDE = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_NEAR = CFG_IDX_W'(1);

    typedef enum logic [1:0] {
        SIDE_TOP    = 2'd0,
        SIDE_LEFT   = 2'd1,
        SIDE_BOTTOM = 2'd2,
        SIDE_RIGHT  = 2'd3
    } side_t;

    typedef enum logic [2:0] {
        DIR_P_STEEP = 3'd0,
        DIR_P_HIGH  = 3'd1,
        DIR_P_LOW   = 3'd2,
        DIR_FLAT    = 3'd3,
        DIR_N_LOW   = 3'd4,
        DIR_N_HIGH  = 3'd5,
        DIR_N_STEEP = 3'd6,
        DIR_N_VERT  = 3'd7
    } dir_t;

    typedef logic [COORD_BITS-1:0] coord_t;
    typedef logic signed [DIFF_W-1:0] diff_t;

    typedef struct packed {
        side_t                side;
        logic [LIMIT_W-1:0]   near_limit;
    } cfg_t;

    typedef struct packed {
        dir_t                 direction;
        logic [KEY_BITS-1:0]  key_row;
        logic [KEY_BITS-1:0]  key_col;
        logic                 last_of_run;
    } res_t;

    typedef struct packed {
        logic first_valid;
        res_t first;
        logic second_valid;
        res_t second;
    } push_t;

    function automatic diff_t coord_diff(input coord_t a, input coord_t b);
        coord_diff = $signed({1'b0, a}) - $signed({1'b0, b});
    endfunction

endpackage

[hdl/profile_keypoint_direction_coder_unit.sv]
// path: a point word sits in the input register from the edge that accepts it;
// its results are then pushed into the result buffer registers and show on the
// output from there, once the buffer has room for them
// throughput: one point per cycle; a point that yields two results holds the
// result stage until both go out; output backpressure stalls the input register
// reset: side top, near_limit 5, point count zero, held slope pair 99;
// window and anchor registers hold no reset value
module profile_keypoint_direction_coder_unit (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              point_valid,
    output logic                              point_ready,
    input  logic [pkdc_pkg::COORD_BITS-1:0]   point_row,
    input  logic [pkdc_pkg::COORD_BITS-1:0]   point_col,
    input  logic                              last_point,
    output logic                              result_valid,
    input  logic                              result_ready,
    output logic [2:0]                        direction,
    output logic [pkdc_pkg::KEY_BITS-1:0]     key_row,
    output logic [pkdc_pkg::KEY_BITS-1:0]     key_col,
    output logic                              last_of_run,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [pkdc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [pkdc_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import pkdc_pkg::*;

    cfg_t   cfg;

    logic   a_valid_reg;
    coord_t a_row_reg;
    coord_t a_col_reg;
    logic   a_last_reg;
    logic   a_advance;
    logic   b_free;

    coord_t                     win_row_reg [3];
    coord_t                     win_col_reg [3];
    coord_t                     anchor_row_reg;
    coord_t                     anchor_col_reg;
    coord_t                     anchor_row_next;
    coord_t                     anchor_col_next;
    logic signed [HELD_W-1:0]   held_first_reg;
    logic signed [HELD_W-1:0]   held_second_reg;
    logic signed [HELD_W-1:0]   held_first_next;
    logic signed [HELD_W-1:0]   held_second_next;
    logic [1:0]                 ps_reg;
    logic [1:0]                 ps_next;

    diff_t  s0;
    diff_t  s1;
    diff_t  off_row;
    diff_t  off_col;
    logic   same;
    logic   nearby;
    logic   slope_repeat;
    logic   emit1;
    coord_t anc0_row;
    coord_t anc0_col;
    coord_t anc1_row;
    coord_t anc1_col;
    dir_t   dir_inner;
    dir_t   dir_final;
    push_t  push_data;
    res_t   result;

    pkdc_config u_config (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    assign a_advance   = a_valid_reg && b_free;
    assign point_ready = !a_valid_reg || b_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            a_valid_reg <= 1'b0;
        else if (point_ready)
            a_valid_reg <= point_valid;
    end

    always_ff @(posedge clk)
    begin
        if (point_valid && point_ready)
        begin
            a_row_reg  <= point_row;
            a_col_reg  <= point_col;
            a_last_reg <= last_point;
        end
    end

    // key point decision for the middle of the window
    always_comb
    begin
        if (cfg.side == SIDE_LEFT || cfg.side == SIDE_RIGHT)
        begin
            s0 = coord_diff(win_col_reg[1], win_col_reg[0]);
            s1 = coord_diff(win_col_reg[2], win_col_reg[1]);
        end
        else
        begin
            s0 = coord_diff(win_row_reg[1], win_row_reg[0]);
            s1 = coord_diff(win_row_reg[2], win_row_reg[1]);
        end
        same = (s0 > 0 && s1 > 0) || (s0 < 0 && s1 < 0) || (s0 == 0 && s1 == 0);
        off_col = coord_diff(win_col_reg[1], anchor_col_reg);
        off_row = coord_diff(win_row_reg[1], anchor_row_reg);
        nearby = ($signed(CMP_W'(off_col)) <= $signed(CMP_W'(cfg.near_limit))) &&
                 ($signed(CMP_W'(off_row)) <= $signed(CMP_W'(cfg.near_limit)));
        slope_repeat = (HELD_W'(s0) == held_first_reg) && (HELD_W'(s1) == held_second_reg);
        emit1 = (ps_reg == 2'd3) && !same && !nearby && !slope_repeat;

        // first point of a profile is its own anchor
        if (ps_reg == 2'd0)
        begin
            anc0_row = a_row_reg;
            anc0_col = a_col_reg;
        end
        else
        begin
            anc0_row = anchor_row_reg;
            anc0_col = anchor_col_reg;
        end
        if (emit1)
        begin
            anc1_row = win_row_reg[1];
            anc1_col = win_col_reg[1];
        end
        else
        begin
            anc1_row = anc0_row;
            anc1_col = anc0_col;
        end

        if (a_last_reg)
        begin
            anchor_row_next  = a_row_reg;
            anchor_col_next  = a_col_reg;
            held_first_next  = HELD_RESET;
            held_second_next = HELD_RESET;
            ps_next          = 2'd0;
        end
        else
        begin
            anchor_row_next  = anc1_row;
            anchor_col_next  = anc1_col;
            held_first_next  = emit1 ? HELD_W'(s0) : held_first_reg;
            held_second_next = emit1 ? HELD_W'(s1) : held_second_reg;
            ps_next          = (ps_reg == 2'd3) ? ps_reg : ps_reg + 2'd1;
        end
    end

    pkdc_sector u_sector_inner (
        .side      (cfg.side),
        .key_row   (win_row_reg[1]),
        .key_col   (win_col_reg[1]),
        .anc_row   (anchor_row_reg),
        .anc_col   (anchor_col_reg),
        .direction (dir_inner)
    );

    pkdc_sector u_sector_final (
        .side      (cfg.side),
        .key_row   (a_row_reg),
        .key_col   (a_col_reg),
        .anc_row   (anc1_row),
        .anc_col   (anc1_col),
        .direction (dir_final)
    );

    always_comb
    begin
        push_data.first_valid         = emit1;
        push_data.first.direction     = dir_inner;
        push_data.first.key_row       = KEY_BITS'(win_row_reg[1]);
        push_data.first.key_col       = KEY_BITS'(win_col_reg[1]);
        push_data.first.last_of_run   = 1'b0;
        push_data.second_valid        = a_last_reg;
        push_data.second.direction    = dir_final;
        push_data.second.key_row      = KEY_BITS'(a_row_reg);
        push_data.second.key_col      = KEY_BITS'(a_col_reg);
        push_data.second.last_of_run  = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ps_reg          <= 2'd0;
            held_first_reg  <= HELD_RESET;
            held_second_reg <= HELD_RESET;
        end
        else if (a_advance)
        begin
            ps_reg          <= ps_next;
            held_first_reg  <= held_first_next;
            held_second_reg <= held_second_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_advance)
        begin
            win_row_reg[0] <= win_row_reg[1];
            win_row_reg[1] <= win_row_reg[2];
            win_row_reg[2] <= a_row_reg;
            win_col_reg[0] <= win_col_reg[1];
            win_col_reg[1] <= win_col_reg[2];
            win_col_reg[2] <= a_col_reg;
            anchor_row_reg <= anchor_row_next;
            anchor_col_reg <= anchor_col_next;
        end
    end

    pkdc_result_buf u_result_buf (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (a_advance),
        .push_data    (push_data),
        .free         (b_free),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    assign direction   = result.direction;
    assign key_row     = result.key_row;
    assign key_col     = result.key_col;
    assign last_of_run = result.last_of_run;

    a_profile_restart: assert property (@(posedge clk) disable iff (!rst_n)
        a_advance && a_last_reg |=> (ps_reg == 2'd0) && (held_first_reg == HELD_RESET))
        else $error("profile state not cleared after last point");

    a_anchor_moves: assert property (@(posedge clk) disable iff (!rst_n)
        a_advance && emit1 && !a_last_reg |=> anchor_col_reg == $past(win_col_reg[1]))
        else $error("anchor not moved to new key point");

    a_inner_needs_window: assert property (@(posedge clk) disable iff (!rst_n)
        a_advance && (ps_reg != 2'd3) |-> !push_data.first_valid)
        else $error("inner key point judged before window filled");

endmodule

[hdl/pkdc_config.sv]
module pkdc_config (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [pkdc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [pkdc_pkg::CFG_DATA_W-1:0]   cfg_data,
    output pkdc_pkg::cfg_t                    cfg
);
    import pkdc_pkg::*;

    side_t              side_reg;
    side_t              side_next;
    logic [LIMIT_W-1:0] near_reg;
    logic [LIMIT_W-1:0] near_next;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        side_next = side_reg;
        near_next = near_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                CFG_SIDE: side_next = side_t'(cfg_data[1:0]);
                CFG_NEAR: near_next = cfg_data[LIMIT_W-1:0];
                default:  ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side_reg <= SIDE_TOP;
            near_reg <= NEAR_RESET;
        end
        else
        begin
            side_reg <= side_next;
            near_reg <= near_next;
        end
    end

    assign cfg.side       = side_reg;
    assign cfg.near_limit = near_reg;

endmodule

[hdl/pkdc_sector.sv]
module pkdc_sector (
    input  pkdc_pkg::side_t   side,
    input  pkdc_pkg::coord_t  key_row,
    input  pkdc_pkg::coord_t  key_col,
    input  pkdc_pkg::coord_t  anc_row,
    input  pkdc_pkg::coord_t  anc_col,
    output pkdc_pkg::dir_t    direction
);
    import pkdc_pkg::*;

    localparam int PROD_W = COORD_BITS + TAN_W;

    diff_t                 d_row;
    diff_t                 d_col;
    diff_t                 num;
    diff_t                 den;
    diff_t                 num_neg;
    diff_t                 den_neg;
    logic [COORD_BITS-1:0] an;
    logic [COORD_BITS-1:0] ad;
    logic                  neg;
    logic [PROD_W-1:0]     x;
    logic [PROD_W-1:0]     t225;
    logic [PROD_W-1:0]     t45;
    logic [PROD_W-1:0]     t675;

    always_comb
    begin
        d_row = coord_diff(key_row, anc_row);
        d_col = coord_diff(anc_col, key_col);
        if (side == SIDE_LEFT || side == SIDE_RIGHT)
        begin
            num = d_col;
            den = d_row;
        end
        else
        begin
            num = d_row;
            den = d_col;
        end
        num_neg = -num;
        den_neg = -den;
        an = num[DIFF_W-1] ? num_neg[COORD_BITS-1:0] : num[COORD_BITS-1:0];
        ad = den[DIFF_W-1] ? den_neg[COORD_BITS-1:0] : den[COORD_BITS-1:0];
        // right side mirrors the angle
        neg = (num[DIFF_W-1] != den[DIFF_W-1]) ^ (side == SIDE_RIGHT);

        x    = PROD_W'({an, {FRAC_BITS{1'b0}}});
        t225 = PROD_W'(TAN225_Q24) * PROD_W'(ad);
        t45  = PROD_W'(TAN45_Q24) * PROD_W'(ad);
        t675 = PROD_W'(TAN675_Q24) * PROD_W'(ad);

        if (num == '0)
            direction = DIR_FLAT;
        else if (den == '0)
            direction = DIR_P_STEEP;
        else if (!neg)
        begin
            if (x >= t675)
                direction = DIR_P_STEEP;
            else if (x >= t45)
                direction = DIR_P_HIGH;
            else if (x >= t225)
                direction = DIR_P_LOW;
            else
                direction = DIR_FLAT;
        end
        else
        begin
            if (x <= t225)
                direction = DIR_N_LOW;
            else if (x <= t45)
                direction = DIR_N_HIGH;
            else if (x <= t675)
                direction = DIR_N_STEEP;
            else
                direction = DIR_N_VERT;
        end
    end

endmodule

[hdl/pkdc_result_buf.sv]
module pkdc_result_buf (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  pkdc_pkg::push_t      push_data,
    output logic                 free,
    output logic                 result_valid,
    input  logic                 result_ready,
    output pkdc_pkg::res_t       result
);
    import pkdc_pkg::*;

    res_t       slot_reg [2];
    res_t       slot_next [2];
    logic [1:0] cnt_reg;
    logic [1:0] cnt_next;
    logic       pop;

    always_comb
    begin
        pop  = (cnt_reg != 2'd0) && result_ready;
        // room once the last held word goes out this cycle
        free = (cnt_reg == 2'd0) || ((cnt_reg == 2'd1) && result_ready);
        slot_next[0] = slot_reg[0];
        slot_next[1] = slot_reg[1];
        cnt_next     = cnt_reg;
        if (push)
        begin
            if (push_data.first_valid)
            begin
                slot_next[0] = push_data.first;
                slot_next[1] = push_data.second;
                cnt_next     = push_data.second_valid ? 2'd2 : 2'd1;
            end
            else
            begin
                slot_next[0] = push_data.second;
                cnt_next     = push_data.second_valid ? 2'd1 : 2'd0;
            end
        end
        else if (pop)
        begin
            slot_next[0] = slot_reg[1];
            cnt_next     = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= 2'd0;
        else
            cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        slot_reg[0] <= slot_next[0];
        slot_reg[1] <= slot_next[1];
    end

    assign result_valid = (cnt_reg != 2'd0);
    assign result       = slot_reg[0];

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg != 2'd3)
        else $error("result buffer count out of range");

    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> free)
        else $error("push into a full result buffer");

    a_hold_pair: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == 2'd2) && result_ready && !push |=> cnt_reg == 2'd1)
        else $error("second word lost from result buffer");

endmodule
